FILE: rtl/kmsd_pkg.sv
// kmsd_pkg: shared types, register indexes and the key code table for the
// keypad matrix scan and debounce core; no dependencies
`default_nettype none

package kmsd_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_STABLE_SCANS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CHANGES  = 2'd1;

   localparam logic [7:0] STABLE_SCANS_RESET = 8'd10;
   localparam logic [7:0] MAX_CHANGES_RESET  = 8'd20;
   localparam logic [7:0] CHANGES_MAX        = 8'd255;
   localparam logic [1:0] LAST_COLUMN        = 2'd3;

   typedef enum logic [1:0] {
      OUTCOME_RUN     = 2'd0,
      OUTCOME_SETTLED = 2'd1,
      OUTCOME_GAVE_UP = 2'd2
   } outcome_type;

   typedef struct packed {
      logic [7:0] stable_scans;
      logic [7:0] max_changes;
   } cfg_type;

   typedef struct packed {
      logic        active;
      logic [1:0]  column;
      logic [15:0] assembly;
      logic [15:0] candidate;
      logic [7:0]  countdown;
      logic [7:0]  changes;
      logic [15:0] accepted;
   } state_type;

   typedef struct packed {
      logic [1:0]  drive_column;
      logic        drive_all;
      outcome_type outcome;
      logic [15:0] key_map;
      logic        key_event;
      logic [7:0]  key_ascii;
      logic        ascii_valid;
   } rsp_type;

   localparam logic [7:0] KEY_CODES [16] = '{
      8'h41, 8'h42, 8'h43, 8'h44, 8'h33, 8'h36, 8'h39, 8'h46,
      8'h32, 8'h35, 8'h38, 8'h30, 8'h31, 8'h34, 8'h37, 8'h45
   };

   // code of the lowest set bit, 0 for an empty map
   function automatic logic [7:0] key_lookup(input logic [15:0] map);
      logic [7:0] code;
      code = 8'h00;
      for (int i = 15; i >= 0; i--) begin
         if (map[4'(i)]) begin
            code = KEY_CODES[4'(i)];
         end
      end
      return code;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/kmsd_step.sv
// kmsd_step: next session state and result for one accepted transaction
// depends on kmsd_pkg
`default_nettype none

module kmsd_step (
   input  wire  kmsd_pkg::cfg_type   cfg,
   input  wire  kmsd_pkg::state_type state_cur,
   input  wire  logic                start_req,
   input  wire  logic [3:0]          row_levels,
   output kmsd_pkg::state_type       state_nxt,
   output kmsd_pkg::rsp_type         rsp
);

   always_comb begin
      kmsd_pkg::state_type   s;
      kmsd_pkg::outcome_type outcome;
      logic                  event_hit;
      logic                  check;

      s         = state_cur;
      outcome   = kmsd_pkg::OUTCOME_RUN;
      event_hit = 1'b0;
      check     = 1'b0;

      if (start_req) begin
         s.active    = 1'b1;
         s.column    = 2'd0;
         s.assembly  = 16'h0000;
         s.candidate = state_cur.accepted;
         s.countdown = cfg.stable_scans;
         s.changes   = 8'd0;
         check       = 1'b1;
      end else if (state_cur.active) begin
         // active-low rows: a low row marks a pressed key
         s.assembly[{state_cur.column, 2'b00} +: 4] = ~row_levels;
         if (state_cur.column == kmsd_pkg::LAST_COLUMN) begin
            s.column = 2'd0;
            if (s.assembly == state_cur.candidate) begin
               if (state_cur.countdown != 8'd0) begin
                  s.countdown = state_cur.countdown - 8'd1;
               end
            end else begin
               s.countdown = cfg.stable_scans;
               s.candidate = s.assembly;
               if (state_cur.changes != kmsd_pkg::CHANGES_MAX) begin
                  s.changes = state_cur.changes + 8'd1;
               end
            end
            check = 1'b1;
         end else begin
            s.column = state_cur.column + 2'd1;
         end
      end

      if (check) begin
         if (s.countdown == 8'd0) begin
            if (s.candidate != s.accepted) begin
               s.accepted = s.candidate;
               event_hit  = (s.candidate != 16'h0000);
            end
            s.active = 1'b0;
            s.column = 2'd0;
            outcome  = kmsd_pkg::OUTCOME_SETTLED;
         end else if (s.changes >= cfg.max_changes) begin
            s.active = 1'b0;
            s.column = 2'd0;
            outcome  = kmsd_pkg::OUTCOME_GAVE_UP;
         end
      end

      state_nxt            = s;
      rsp.drive_column     = s.active ? s.column : 2'd0;
      rsp.drive_all        = ~s.active;
      rsp.outcome          = outcome;
      rsp.key_map          = s.accepted;
      rsp.key_event        = event_hit;
      rsp.key_ascii        = kmsd_pkg::key_lookup(s.accepted);
      rsp.ascii_valid      = (s.accepted != 16'h0000);
   end

endmodule

`default_nettype wire

FILE: rtl/kmsd_rsp_buf.sv
// kmsd_rsp_buf: result register with one skid entry between step logic and
// the result channel; depends on kmsd_pkg
`default_nettype none

module kmsd_rsp_buf (
   input  wire  logic              clock,
   input  wire  logic              reset,
   input  wire  logic              push,
   input  wire  kmsd_pkg::rsp_type push_data,
   output logic                    full,
   output logic                    rsp_valid,
   input  wire  logic              rsp_stall,
   output kmsd_pkg::rsp_type       rsp_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   kmsd_pkg::rsp_type main_data_ff, main_data_in;
   kmsd_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              pop;

   assign pop = main_valid_ff & ~rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no push while the skid entry is held
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_data_in  = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;

endmodule

`default_nettype wire

FILE: rtl/keypad_matrix_scan_debounce_core.sv
// keypad_matrix_scan_debounce_core: top level of the 4x4 keypad scanner with
// debounce; depends on kmsd_pkg, kmsd_step and kmsd_rsp_buf
`default_nettype none

// Scans a 4x4 active-low key matrix and debounces it. Each request
// transaction carries one row sample (or a start request, which opens a
// debounce session at column 0) and yields exactly one response transaction
// telling which column to drive next, whether all columns should be driven
// (idle), whether the session settled or gave up on this sample, the accepted
// key map, a key event flag and the ASCII code of the lowest pressed key.
// One transaction per clock is sustained while req_stall is low: the session
// state is updated by a single pass of logic between the session registers
// and the response register, which registers each response. A one-entry
// skid behind the response register lets a request be taken while a finished
// response is still stalled; req_stall rises only when both are occupied.
// The csr port writes stable_scans (index 0) and max_changes (index 1) and
// should be used only while no transaction is outstanding.

module keypad_matrix_scan_debounce_core (
   input  wire  logic                               clock,
   input  wire  logic                               reset,
   // configuration writes
   input  wire  logic                               csr_wr_en,
   input  wire  logic [kmsd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  logic [kmsd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // request channel
   input  wire  logic                               req_valid,
   output logic                                     req_stall,
   input  wire  logic                               req_start_req,
   input  wire  logic [3:0]                         req_row_levels,
   // response channel
   output logic                                     rsp_valid,
   input  wire  logic                               rsp_stall,
   output logic [1:0]                               rsp_drive_column,
   output logic                                     rsp_drive_all,
   output logic [1:0]                               rsp_outcome,
   output logic [15:0]                              rsp_key_map,
   output logic                                     rsp_key_event,
   output logic [7:0]                               rsp_key_ascii,
   output logic                                     rsp_ascii_valid
);

   kmsd_pkg::cfg_type   cfg_ff, cfg_in;
   kmsd_pkg::state_type state_ff;
   kmsd_pkg::state_type state_in;
   kmsd_pkg::rsp_type   step_rsp;
   kmsd_pkg::rsp_type   rsp_data;
   logic                buf_full;
   logic                req_accept;

   // request taken whenever the skid entry is free
   assign req_stall  = buf_full;
   assign req_accept = req_valid & ~buf_full;

   // configuration registers, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            kmsd_pkg::CSR_STABLE_SCANS: cfg_in.stable_scans = csr_wdata;
            kmsd_pkg::CSR_MAX_CHANGES:  cfg_in.max_changes  = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stable_scans <= kmsd_pkg::STABLE_SCANS_RESET;
         cfg_ff.max_changes  <= kmsd_pkg::MAX_CHANGES_RESET;
         state_ff            <= '0;
      end else begin
         cfg_ff <= cfg_in;
         // session state moves only with an accepted transaction
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   // per-sample session update and response fields
   kmsd_step u_step (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .start_req  (req_start_req),
      .row_levels (req_row_levels),
      .state_nxt  (state_in),
      .rsp        (step_rsp)
   );

   // response register plus skid entry
   kmsd_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (step_rsp),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_drive_column = rsp_data.drive_column;
   assign rsp_drive_all    = rsp_data.drive_all;
   assign rsp_outcome      = rsp_data.outcome;
   assign rsp_key_map      = rsp_data.key_map;
   assign rsp_key_event    = rsp_data.key_event;
   assign rsp_key_ascii    = rsp_data.key_ascii;
   assign rsp_ascii_valid  = rsp_data.ascii_valid;

   // a held skid entry means the response register is occupied
   a_skid_implies_main: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid entry held with empty response register");

   // a finished session always returns to idle driving
   a_end_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome == kmsd_pkg::OUTCOME_SETTLED ||
                     rsp_outcome == kmsd_pkg::OUTCOME_GAVE_UP))
      |-> (rsp_drive_all && rsp_drive_column == 2'd0))
      else $error("session ended without returning to idle");

   // a key event only on a settling sample with a pressed key
   a_event_settled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_key_event)
      |-> (rsp_outcome == kmsd_pkg::OUTCOME_SETTLED && rsp_key_map != 16'h0000))
      else $error("key event outside a settled nonempty map");

   // idle session state keeps the column at zero
   a_idle_column: assert property (@(posedge clock) disable iff (reset)
      !state_ff.active |-> (state_ff.column == 2'd0))
      else $error("scan column nonzero while idle");

endmodule

`default_nettype wire
